// ----- hw/rtl/ccls_pkg.sv -----
// Package for the cyclic competition lattice step block: field widths, codes,
// register indexes and reset values, state and kind types, dominance lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ccls_pkg;

   // lattice geometry default and queue depth between front and back
   localparam int unsigned SIDE_DEFAULT = 64;
   localparam int unsigned QUEUE_DEPTH  = 2;

   // field widths
   localparam int unsigned CMD_W   = 2;
   localparam int unsigned IDX_W   = 12;
   localparam int unsigned DIR_W   = 3;
   localparam int unsigned DRAW_W  = 16;
   localparam int unsigned CODE_W  = 3;
   localparam int unsigned OUT_W   = 3;
   localparam int unsigned DOM_W   = 49;
   localparam int unsigned LIMIT_W = 16;

   // stream and register port widths
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 24;
   localparam int unsigned RSP_PAD_W  = RSP_DATA_W - OUT_W - IDX_W - CODE_W;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 49;

   // commands carried in req_tuser
   typedef enum logic [CMD_W-1:0] {
      CMD_STEP   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_READ   = 2'd2,
      CMD_UNUSED = 2'd3
   } command_type;

   // neighbour directions
   typedef enum logic [DIR_W-1:0] {
      DIR_UP         = 3'd0,
      DIR_DOWN       = 3'd1,
      DIR_LEFT       = 3'd2,
      DIR_RIGHT      = 3'd3,
      DIR_UP_LEFT    = 3'd4,
      DIR_UP_RIGHT   = 3'd5,
      DIR_DOWN_LEFT  = 3'd6,
      DIR_DOWN_RIGHT = 3'd7
   } direction_type;

   // result outcome codes
   localparam logic [OUT_W-1:0] OUT_NONE         = 3'd0;
   localparam logic [OUT_W-1:0] OUT_SWAP         = 3'd1;
   localparam logic [OUT_W-1:0] OUT_NB_EMPTIED   = 3'd2;
   localparam logic [OUT_W-1:0] OUT_CELL_EMPTIED = 3'd3;
   localparam logic [OUT_W-1:0] OUT_NB_FILLED    = 3'd4;
   localparam logic [OUT_W-1:0] OUT_CELL_FILLED  = 3'd5;
   localparam logic [OUT_W-1:0] OUT_ACCESS       = 3'd6;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SPECIES_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOMINANCE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EIGHT_NB      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_EDGES    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIGRATE_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERACT_LIMIT = 3'd5;

   // configuration reset values
   localparam logic [CODE_W-1:0]  RST_SPECIES_COUNT  = 3'd5;
   localparam logic [DOM_W-1:0]   RST_DOMINANCE      = '0;
   localparam logic               RST_EIGHT_NB       = 1'b0;
   localparam logic               RST_WRAP_EDGES     = 1'b1;
   localparam logic [LIMIT_W-1:0] RST_MIGRATE_LIMIT  = 16'd16384;
   localparam logic [LIMIT_W-1:0] RST_INTERACT_LIMIT = 16'd49152;

   // what the back end does with a queued transaction
   typedef enum logic [2:0] {
      KIND_ZERO  = 3'd0,  // unused command or step outside the lattice
      KIND_STEP  = 3'd1,
      KIND_WRITE = 3'd2,
      KIND_READ  = 3'd3,
      KIND_VOID  = 3'd4   // cell access outside the lattice
   } item_kind_type;

   // back end sequencer
   typedef enum logic [1:0] {
      ST_CLEAR  = 2'd0,
      ST_READ   = 2'd1,
      ST_EVAL   = 2'd2,
      ST_WRITE2 = 2'd3
   } back_state_type;

   // species win beats species lose; empty cells and bits past the matrix never win
   function automatic logic beats(input logic [CODE_W-1:0]  win,
                                  input logic [CODE_W-1:0]  lose,
                                  input logic [CODE_W-1:0]  count,
                                  input logic [DOM_W-1:0]   dom);
      logic [5:0] bit_pos;
      logic       result;
      bit_pos = 6'(win - 3'd1) * 6'(count) + 6'(lose - 3'd1);
      result  = 1'b0;
      if ((win != '0) && (lose != '0) && (bit_pos < 6'(DOM_W))) begin
         result = dom[bit_pos];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ccls_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ccls_ram #(
   parameter int unsigned WIDTH = 3,
   parameter int unsigned DEPTH = 4096,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ccls_fifo.sv -----
// Short queue between the front end and the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ccls_fifo #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 2,
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ccls_front.sv -----
// Front end: accepts request transactions, splits the cell index into row and
// column, finds the neighbour index and classifies the command. Uses ccls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccls_front import ccls_pkg::*; #(
   parameter int unsigned SIDE = SIDE_DEFAULT,
   localparam int unsigned AW  = $clog2(SIDE * SIDE)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]      req_tuser,
   input  logic                  eight_neighbours,
   input  logic                  wrap_edges,
   output logic                  push_valid,
   input  logic                  push_ready,
   output item_kind_type         push_kind,
   output logic [AW-1:0]         push_idx,
   output logic [AW-1:0]         push_nidx,
   output logic [DRAW_W-1:0]     push_draw,
   output logic [CODE_W-1:0]     push_wval
);

   localparam int unsigned CELLS       = SIDE * SIDE;
   localparam int unsigned CW          = $clog2(SIDE);
   localparam int unsigned MOD         = 1 << AW;
   localparam int unsigned RECIP_SHIFT = 24;
   localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / SIDE;
   localparam int unsigned PROD_W      = IDX_W + RECIP_SHIFT;

   // index offsets, modulo 2**AW
   localparam logic [AW-1:0] STEP_ROW_DN       = AW'(SIDE);
   localparam logic [AW-1:0] STEP_ROW_UP       = AW'(MOD - SIDE);
   localparam logic [AW-1:0] STEP_ROW_TO_LAST  = AW'(SIDE * (SIDE - 1));
   localparam logic [AW-1:0] STEP_ROW_TO_FIRST = AW'(MOD - SIDE * (SIDE - 1));
   localparam logic [AW-1:0] STEP_COL_RT       = AW'(1);
   localparam logic [AW-1:0] STEP_COL_LT       = AW'(MOD - 1);
   localparam logic [AW-1:0] STEP_COL_TO_LAST  = AW'(SIDE - 1);
   localparam logic [AW-1:0] STEP_COL_TO_FIRST = AW'(MOD - (SIDE - 1));

   logic                accept;
   logic [PROD_W-1:0]   prod;

   logic                s0_valid_ff, s0_valid_in;
   command_type         s0_cmd_ff;
   logic [IDX_W-1:0]    s0_idx_ff;
   logic [DIR_W-1:0]    s0_dir_ff;
   logic [DRAW_W-1:0]   s0_draw_ff;
   logic [CODE_W-1:0]   s0_wval_ff;
   logic [IDX_W-1:0]    s0_qest_ff;

   logic [IDX_W:0]      qs, rem;
   logic [IDX_W-1:0]    row;
   logic [CW-1:0]       col;
   logic                in_range;
   direction_type       dir_eff;
   logic                go_up, go_down, go_left, go_right;
   logic [AW-1:0]       row_step, col_step;

   assign req_tready = enable && (!s0_valid_ff || push_ready);
   assign accept     = req_tvalid && req_tready;

   // row estimate by reciprocal multiply; low by at most one
   assign prod = PROD_W'(req_tdata[IDX_W-1:0]) * PROD_W'(RECIP);

   // input stage
   always_comb begin
      s0_valid_in = s0_valid_ff;
      if (accept) begin
         s0_valid_in = 1'b1;
      end else if (push_ready) begin
         s0_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_cmd_ff  <= command_type'(req_tuser);
         s0_idx_ff  <= req_tdata[IDX_W-1:0];
         s0_dir_ff  <= req_tdata[IDX_W +: DIR_W];
         s0_draw_ff <= req_tdata[IDX_W + DIR_W +: DRAW_W];
         s0_wval_ff <= req_tdata[IDX_W + DIR_W + DRAW_W +: CODE_W];
         s0_qest_ff <= IDX_W'(prod >> RECIP_SHIFT);
      end
   end

   // remainder correction gives row and column
   always_comb begin
      qs  = (IDX_W + 1)'(s0_qest_ff) * (IDX_W + 1)'(SIDE);
      rem = {1'b0, s0_idx_ff} - qs;
      if (rem >= (IDX_W + 1)'(SIDE)) begin
         row = s0_qest_ff + 1'b1;
         col = CW'(rem - (IDX_W + 1)'(SIDE));
      end else begin
         row = s0_qest_ff;
         col = CW'(rem);
      end
      in_range = (32'(s0_idx_ff) < 32'(CELLS));
   end

   // direction decode; four-neighbour mode keeps the low two bits
   always_comb begin
      dir_eff  = eight_neighbours ? direction_type'(s0_dir_ff)
                                  : direction_type'({1'b0, s0_dir_ff[1:0]});
      go_up    = 1'b0;
      go_down  = 1'b0;
      go_left  = 1'b0;
      go_right = 1'b0;
      case (dir_eff)
         DIR_UP:         go_up = 1'b1;
         DIR_DOWN:       go_down = 1'b1;
         DIR_LEFT:       go_left = 1'b1;
         DIR_RIGHT:      go_right = 1'b1;
         DIR_UP_LEFT:    begin go_up = 1'b1;   go_left = 1'b1;  end
         DIR_UP_RIGHT:   begin go_up = 1'b1;   go_right = 1'b1; end
         DIR_DOWN_LEFT:  begin go_down = 1'b1; go_left = 1'b1;  end
         DIR_DOWN_RIGHT: begin go_down = 1'b1; go_right = 1'b1; end
         default:        ;
      endcase
   end

   // index offsets: wrap jumps to the far edge, reflect reverses the move
   always_comb begin
      row_step = '0;
      col_step = '0;
      if (go_up) begin
         if (row == '0) begin
            row_step = wrap_edges ? STEP_ROW_TO_LAST : STEP_ROW_DN;
         end else begin
            row_step = STEP_ROW_UP;
         end
      end else if (go_down) begin
         if (row == IDX_W'(SIDE - 1)) begin
            row_step = wrap_edges ? STEP_ROW_TO_FIRST : STEP_ROW_UP;
         end else begin
            row_step = STEP_ROW_DN;
         end
      end
      if (go_left) begin
         if (col == '0) begin
            col_step = wrap_edges ? STEP_COL_TO_LAST : STEP_COL_RT;
         end else begin
            col_step = STEP_COL_LT;
         end
      end else if (go_right) begin
         if (col == CW'(SIDE - 1)) begin
            col_step = wrap_edges ? STEP_COL_TO_FIRST : STEP_COL_LT;
         end else begin
            col_step = STEP_COL_RT;
         end
      end
   end

   // classification
   always_comb begin
      case (s0_cmd_ff)
         CMD_STEP:  push_kind = in_range ? KIND_STEP : KIND_ZERO;
         CMD_WRITE: push_kind = in_range ? KIND_WRITE : KIND_VOID;
         CMD_READ:  push_kind = in_range ? KIND_READ : KIND_VOID;
         default:   push_kind = KIND_ZERO;
      endcase
   end

   assign push_valid = s0_valid_ff;
   assign push_idx   = AW'(s0_idx_ff);
   assign push_nidx  = AW'(s0_idx_ff) + row_step + col_step;
   assign push_draw  = s0_draw_ff;
   assign push_wval  = s0_wval_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ccls_back.sv -----
// Back end: holds the lattice memory, clears it after reset, reads both cells,
// applies the chosen action and holds the response register. Uses ccls_pkg,
// ccls_ram.
`timescale 1ns / 1ps
`default_nettype none

module ccls_back import ccls_pkg::*; #(
   parameter int unsigned SIDE = SIDE_DEFAULT,
   localparam int unsigned AW  = $clog2(SIDE * SIDE)
) (
   input  logic                clock,
   input  logic                reset,
   output logic                lattice_ready,
   input  logic                head_valid,
   output logic                pop,
   input  item_kind_type       head_kind,
   input  logic [AW-1:0]       head_idx,
   input  logic [AW-1:0]       head_nidx,
   input  logic [DRAW_W-1:0]   head_draw,
   input  logic [CODE_W-1:0]   head_wval,
   input  logic [CODE_W-1:0]   species_count,
   input  logic [DOM_W-1:0]    dominance_bits,
   input  logic [LIMIT_W-1:0]  migrate_limit,
   input  logic [LIMIT_W-1:0]  interact_limit,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [OUT_W-1:0]    rsp_outcome,
   output logic [IDX_W-1:0]    rsp_nidx,
   output logic [CODE_W-1:0]   rsp_value
);

   localparam int unsigned CELLS = SIDE * SIDE;

   back_state_type     state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [CODE_W-1:0]  swap_val_ff, swap_val_in;

   logic               ram_we;
   logic [AW-1:0]      ram_addr;
   logic [CODE_W-1:0]  ram_data;
   logic [CODE_W-1:0]  a, b;

   logic               out_free, load_rsp;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   rsp_outcome_ff;
   logic [IDX_W-1:0]   rsp_nidx_ff;
   logic [CODE_W-1:0]  rsp_value_ff;

   logic               beat_ab, beat_ba;
   logic [OUT_W-1:0]   d_outcome;
   logic [IDX_W-1:0]   d_nidx;
   logic [CODE_W-1:0]  d_value;
   logic               d_wr_en, d_wr_nb, d_two;
   logic [CODE_W-1:0]  d_wr_data;

   ccls_ram #(
      .WIDTH (CODE_W),
      .DEPTH (CELLS)
   ) u_lattice (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_addr),
      .wr_data   (ram_data),
      .rd_addr_a (head_idx),
      .rd_data_a (a),
      .rd_addr_b (head_nidx),
      .rd_data_b (b)
   );

   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign lattice_ready = (state_ff != ST_CLEAR);

   // action decision on the two cells read
   always_comb begin
      beat_ab   = beats(a, b, species_count, dominance_bits);
      beat_ba   = beats(b, a, species_count, dominance_bits);
      d_outcome = OUT_NONE;
      d_nidx    = '0;
      d_value   = '0;
      d_wr_en   = 1'b0;
      d_wr_nb   = 1'b0;
      d_two     = 1'b0;
      d_wr_data = '0;
      case (head_kind)
         KIND_STEP: begin
            d_nidx  = IDX_W'(head_nidx);
            d_value = a;
            if (a != b) begin
               if (head_draw < migrate_limit) begin
                  // migration: cell takes b now, neighbour takes a next cycle
                  d_outcome = OUT_SWAP;
                  d_wr_en   = 1'b1;
                  d_wr_data = b;
                  d_two     = 1'b1;
                  d_value   = b;
               end else if (head_draw < interact_limit) begin
                  if (b != '0) begin
                     if (beat_ab) begin
                        d_outcome = OUT_NB_EMPTIED;
                        d_wr_en   = 1'b1;
                        d_wr_nb   = 1'b1;
                     end else if (beat_ba) begin
                        d_outcome = OUT_CELL_EMPTIED;
                        d_wr_en   = 1'b1;
                        d_value   = '0;
                     end
                  end
               end else begin
                  if (b == '0) begin
                     d_outcome = OUT_NB_FILLED;
                     d_wr_en   = 1'b1;
                     d_wr_nb   = 1'b1;
                     d_wr_data = a;
                  end else if (a == '0) begin
                     d_outcome = OUT_CELL_FILLED;
                     d_wr_en   = 1'b1;
                     d_wr_data = b;
                     d_value   = b;
                  end
               end
            end
         end
         KIND_WRITE: begin
            d_outcome = OUT_ACCESS;
            d_wr_en   = 1'b1;
            d_wr_data = head_wval;
            d_value   = head_wval;
         end
         KIND_READ: begin
            d_outcome = OUT_ACCESS;
            d_value   = a;
         end
         KIND_VOID: begin
            d_outcome = OUT_ACCESS;
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (head_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (out_free) begin
               state_in = d_two ? ST_WRITE2 : ST_READ;
            end
         end
         ST_WRITE2: state_in = ST_READ;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      ram_we      = 1'b0;
      ram_addr    = head_idx;
      ram_data    = '0;
      pop         = 1'b0;
      load_rsp    = 1'b0;
      clr_in      = clr_ff;
      swap_val_in = swap_val_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ff;
            clr_in   = clr_ff + 1'b1;
         end
         ST_READ: ;
         ST_EVAL: begin
            if (out_free) begin
               load_rsp    = 1'b1;
               ram_we      = d_wr_en;
               ram_addr    = d_wr_nb ? head_nidx : head_idx;
               ram_data    = d_wr_data;
               pop         = !d_two;
               swap_val_in = a;
            end
         end
         ST_WRITE2: begin
            ram_we   = 1'b1;
            ram_addr = head_nidx;
            ram_data = swap_val_ff;
            pop      = 1'b1;
         end
         default: ;
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      swap_val_ff <= swap_val_in;
      if (load_rsp) begin
         rsp_outcome_ff <= d_outcome;
         rsp_nidx_ff    <= d_nidx;
         rsp_value_ff   <= d_value;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_outcome = rsp_outcome_ff;
   assign rsp_nidx    = rsp_nidx_ff;
   assign rsp_value   = rsp_value_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/cyclic_competition_lattice_step.sv -----
// Top level of the cyclic competition lattice step block: configuration
// registers, front end, queue and back end. Uses ccls_pkg, ccls_front,
// ccls_fifo, ccls_back.
//
//   channel  ports          direction  contents
//   req      req_t*         in         one command transaction (step, write, read)
//   rsp      rsp_t*         out        one result per request transaction
//   csr      csr_*          in         register write, index and data
//
// After reset the lattice memory is swept to zero, one cell a cycle, over all SIDE*SIDE
// cells (4096 at SIDE = 64); req_tready stays low meanwhile, csr writes are taken.
// The front end holds each transaction in its input register and takes a new
// transaction each cycle while the queue has room. The back end handles a transaction
// in ST_READ (registered read of both cells), then ST_EVAL (decide and write); a
// migration adds ST_WRITE2, whose second write shares the single memory write port.
// A stalled response holds in its register; the back end waits in its decide cycle.
`timescale 1ns / 1ps
`default_nettype none

module cyclic_competition_lattice_step import ccls_pkg::*; #(
   parameter int unsigned SIDE = SIDE_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // cell_index[11:0], direction[14:12], action_draw[30:15], write_value[33:31]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command[1:0]
   input  logic [CMD_W-1:0]      req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // outcome[2:0], neighbour_index[14:3], cell_value[17:15]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned AW      = $clog2(SIDE * SIDE);
   localparam int unsigned KIND_W  = $bits(item_kind_type);
   localparam int unsigned ENTRY_W = KIND_W + 2 * AW + DRAW_W + CODE_W;

   logic [CODE_W-1:0]  species_count_ff;
   logic [DOM_W-1:0]   dominance_ff;
   logic               eight_nb_ff;
   logic               wrap_edges_ff;
   logic [LIMIT_W-1:0] migrate_limit_ff;
   logic [LIMIT_W-1:0] interact_limit_ff;

   logic               lattice_ready;
   logic               push_valid, push_ready;
   item_kind_type      push_kind;
   logic [AW-1:0]      push_idx, push_nidx;
   logic [DRAW_W-1:0]  push_draw;
   logic [CODE_W-1:0]  push_wval;
   logic [ENTRY_W-1:0] push_entry, head_entry;

   logic               head_valid, pop;
   logic [KIND_W-1:0]  head_kind_bits;
   item_kind_type      head_kind;
   logic [AW-1:0]      head_idx, head_nidx;
   logic [DRAW_W-1:0]  head_draw;
   logic [CODE_W-1:0]  head_wval;

   logic [OUT_W-1:0]   rsp_outcome;
   logic [IDX_W-1:0]   rsp_nidx;
   logic [CODE_W-1:0]  rsp_value;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         species_count_ff  <= RST_SPECIES_COUNT;
         dominance_ff      <= RST_DOMINANCE;
         eight_nb_ff       <= RST_EIGHT_NB;
         wrap_edges_ff     <= RST_WRAP_EDGES;
         migrate_limit_ff  <= RST_MIGRATE_LIMIT;
         interact_limit_ff <= RST_INTERACT_LIMIT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SPECIES_COUNT:  species_count_ff  <= csr_wdata[CODE_W-1:0];
            CSR_DOMINANCE:      dominance_ff      <= csr_wdata[DOM_W-1:0];
            CSR_EIGHT_NB:       eight_nb_ff       <= csr_wdata[0];
            CSR_WRAP_EDGES:     wrap_edges_ff     <= csr_wdata[0];
            CSR_MIGRATE_LIMIT:  migrate_limit_ff  <= csr_wdata[LIMIT_W-1:0];
            CSR_INTERACT_LIMIT: interact_limit_ff <= csr_wdata[LIMIT_W-1:0];
            default:            ;
         endcase
      end
   end

   ccls_front #(
      .SIDE (SIDE)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .enable           (lattice_ready),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .eight_neighbours (eight_nb_ff),
      .wrap_edges       (wrap_edges_ff),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_kind        (push_kind),
      .push_idx         (push_idx),
      .push_nidx        (push_nidx),
      .push_draw        (push_draw),
      .push_wval        (push_wval)
   );

   // queue entry packing
   assign push_entry = {KIND_W'(push_kind), push_idx, push_nidx, push_draw, push_wval};
   assign {head_kind_bits, head_idx, head_nidx, head_draw, head_wval} = head_entry;
   assign head_kind = item_kind_type'(head_kind_bits);

   ccls_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_entry),
      .pop_valid  (head_valid),
      .pop        (pop),
      .pop_data   (head_entry)
   );

   ccls_back #(
      .SIDE (SIDE)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .lattice_ready  (lattice_ready),
      .head_valid     (head_valid),
      .pop            (pop),
      .head_kind      (head_kind),
      .head_idx       (head_idx),
      .head_nidx      (head_nidx),
      .head_draw      (head_draw),
      .head_wval      (head_wval),
      .species_count  (species_count_ff),
      .dominance_bits (dominance_ff),
      .migrate_limit  (migrate_limit_ff),
      .interact_limit (interact_limit_ff),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_outcome    (rsp_outcome),
      .rsp_nidx       (rsp_nidx),
      .rsp_value      (rsp_value)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_value, rsp_nidx, rsp_outcome};

endmodule

`default_nettype wire

// ----- dv/cyclic_competition_lattice_step_test.sv -----
// Self-checking testbench for the cyclic competition lattice step block: a lattice
// predictor checks every result against streamed step, write and read transactions.
// Depends on ccls_pkg and the cyclic_competition_lattice_step RTL.
`timescale 1ns / 1ps

module cyclic_competition_lattice_step_test;
   import ccls_pkg::*;

   localparam int SIDE      = 64;
   localparam int CELLS     = SIDE * SIDE;
   localparam int REQ_PAD_W = REQ_DATA_W - IDX_W - DIR_W - DRAW_W - CODE_W;
   localparam int SENDER    = 0;
   localparam int RECEIVER  = 1;

   typedef struct packed {
      command_type       cmd;
      logic [IDX_W-1:0]  cell_idx;
      direction_type     dir;
      logic [DRAW_W-1:0] draw;
      logic [CODE_W-1:0] value;
   } lattice_request_t;

   typedef struct packed {
      logic [OUT_W-1:0]  outcome;
      logic [IDX_W-1:0]  neighbour;
      logic [CODE_W-1:0] value;
   } lattice_result_t;

   logic                  clock;
   logic                  reset;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [CMD_W-1:0]      req_tuser;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor state: own copy of the lattice and of the registers
   logic [CODE_W-1:0]  cells [CELLS];
   logic [CODE_W-1:0]  cfg_species;
   logic [DOM_W-1:0]   cfg_dominance;
   logic               cfg_eight;
   logic               cfg_wrap;
   logic [LIMIT_W-1:0] cfg_migrate;
   logic [LIMIT_W-1:0] cfg_interact;

   lattice_request_t pending_requests [$];
   lattice_result_t  expected_results [$];

   int   errors = 0;
   int   results_seen = 0;
   int   steady_left [2] = '{0, 0};
   int   req_gap = 0;
   int   rsp_gap = 0;
   int   hold_left = 0;
   int   squeezes = 0;
   logic req_fired = 1'b0;
   logic rsp_fired = 1'b0;

   cyclic_competition_lattice_step #(.SIDE(SIDE)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // dominance lookup; empty cells never win, bits past the matrix read as no win
   function automatic logic species_beats(input logic [CODE_W-1:0] win,
                                          input logic [CODE_W-1:0] lose);
      int bit_pos;
      if (win == '0 || lose == '0) return 1'b0;
      bit_pos = (int'(win) - 1) * int'(cfg_species) + int'(lose) - 1;
      if (bit_pos >= DOM_W) return 1'b0;
      return cfg_dominance[bit_pos];
   endfunction

   // one coordinate step, periodic or reflected at the edge
   function automatic int move_coord(input int pos, input int off);
      int n;
      n = pos + off;
      if (cfg_wrap) return (n + SIDE) % SIDE;
      if (n < 0 || n >= SIDE) n = pos - off;
      return n;
   endfunction

   // applies one transaction to the lattice copy and returns its result
   function automatic lattice_result_t step_lattice(input lattice_request_t rq);
      lattice_result_t   res;
      direction_type     dir;
      int                d_row, d_col, nb;
      logic [CODE_W-1:0] a, b;
      res = '0;
      d_row = 0;
      d_col = 0;
      case (rq.cmd)
         CMD_WRITE, CMD_READ: begin
            if (rq.cmd == CMD_WRITE) cells[rq.cell_idx] = rq.value;
            res.outcome = OUT_ACCESS;
            res.value   = cells[rq.cell_idx];
         end
         CMD_STEP: begin
            dir = cfg_eight ? rq.dir : direction_type'({1'b0, rq.dir[1:0]});
            case (dir)
               DIR_UP:         begin d_row = -1; d_col =  0; end
               DIR_DOWN:       begin d_row =  1; d_col =  0; end
               DIR_LEFT:       begin d_row =  0; d_col = -1; end
               DIR_RIGHT:      begin d_row =  0; d_col =  1; end
               DIR_UP_LEFT:    begin d_row = -1; d_col = -1; end
               DIR_UP_RIGHT:   begin d_row = -1; d_col =  1; end
               DIR_DOWN_LEFT:  begin d_row =  1; d_col = -1; end
               default:        begin d_row =  1; d_col =  1; end
            endcase
            nb = move_coord(int'(rq.cell_idx) / SIDE, d_row) * SIDE
                 + move_coord(int'(rq.cell_idx) % SIDE, d_col);
            a = cells[rq.cell_idx];
            b = cells[nb];
            if (a != b) begin
               if (rq.draw < cfg_migrate) begin
                  cells[rq.cell_idx] = b;
                  cells[nb]          = a;
                  res.outcome        = OUT_SWAP;
               end else if (rq.draw < cfg_interact) begin
                  // predation: a mutual win goes to the chosen cell
                  if (b != '0) begin
                     if (species_beats(a, b)) begin
                        cells[nb]   = '0;
                        res.outcome = OUT_NB_EMPTIED;
                     end else if (species_beats(b, a)) begin
                        cells[rq.cell_idx] = '0;
                        res.outcome        = OUT_CELL_EMPTIED;
                     end
                  end
               end else if (b == '0) begin
                  cells[nb]   = a;
                  res.outcome = OUT_NB_FILLED;
               end else if (a == '0) begin
                  cells[rq.cell_idx] = b;
                  res.outcome        = OUT_CELL_FILLED;
               end
            end
            res.neighbour = nb[IDX_W-1:0];
            res.value     = cells[rq.cell_idx];
         end
         default: ;
      endcase
      return res;
   endfunction

   // idle length: mostly short, a few long, with stretches of none at all
   function automatic int next_gap(input int side);
      int r;
      if (steady_left[side] > 0) begin
         steady_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) steady_left[side] = $urandom_range(20, 80);
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // request driver
   always @(negedge clock) begin : drive_requests
      lattice_request_t rq;
      if (!req_tvalid || req_fired) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            rq = pending_requests.pop_front();
            req_tdata  <= {{REQ_PAD_W{1'b0}}, rq.value, rq.draw, rq.dir, rq.cell_idx};
            req_tuser  <= rq.cmd;
            req_tvalid <= 1'b1;
            req_gap = next_gap(SENDER);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls, plus two long hold-offs to back the block up
   always @(negedge clock) begin : drive_ready
      if ((squeezes == 0 && results_seen >= 150) || (squeezes == 1 && results_seen >= 1100))
      begin
         hold_left = 400;
         squeezes++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_fired) begin
         rsp_gap = next_gap(RECEIVER);
         rsp_tready <= (rsp_gap == 0);
         if (rsp_gap > 0) rsp_gap--;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: check results first, then predict the accepted request
   always @(posedge clock) begin : watch_channels
      lattice_request_t rq;
      lattice_result_t  got, want, predicted;
      if (reset) begin
         req_fired <= 1'b0;
         rsp_fired <= 1'b0;
      end else begin
         req_fired <= req_tvalid && req_tready;
         rsp_fired <= rsp_tvalid && rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            got.outcome   = rsp_tdata[OUT_W-1:0];
            got.neighbour = rsp_tdata[OUT_W +: IDX_W];
            got.value     = rsp_tdata[OUT_W+IDX_W +: CODE_W];
            results_seen++;
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, got %0d/%0d/%0d",
                        $realtime, got.outcome, got.neighbour, got.value);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: mismatch, expected %0d/%0d/%0d, got %0d/%0d/%0d",
                           $realtime, want.outcome, want.neighbour, want.value,
                           got.outcome, got.neighbour, got.value);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            rq.cmd      = command_type'(req_tuser);
            rq.cell_idx = req_tdata[IDX_W-1:0];
            rq.dir      = direction_type'(req_tdata[IDX_W +: DIR_W]);
            rq.draw     = req_tdata[IDX_W+DIR_W +: DRAW_W];
            rq.value    = req_tdata[IDX_W+DIR_W+DRAW_W +: CODE_W];
            predicted   = step_lattice(rq);
            expected_results = {expected_results, predicted};
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
   endtask

   // writes all six registers; only called with the block idle
   task automatic write_settings(input logic [CODE_W-1:0]  species,
                                 input logic [DOM_W-1:0]   dominance,
                                 input logic               eight,
                                 input logic               wrap,
                                 input logic [LIMIT_W-1:0] migrate,
                                 input logic [LIMIT_W-1:0] interact);
      write_reg(CSR_SPECIES_COUNT, CSR_DATA_W'(species));
      write_reg(CSR_DOMINANCE, CSR_DATA_W'(dominance));
      write_reg(CSR_EIGHT_NB, CSR_DATA_W'(eight));
      write_reg(CSR_WRAP_EDGES, CSR_DATA_W'(wrap));
      write_reg(CSR_MIGRATE_LIMIT, CSR_DATA_W'(migrate));
      write_reg(CSR_INTERACT_LIMIT, CSR_DATA_W'(interact));
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_species   = species;
      cfg_dominance = dominance;
      cfg_eight     = eight;
      cfg_wrap      = wrap;
      cfg_migrate   = migrate;
      cfg_interact  = interact;
   endtask

   task automatic add_request(input command_type cmd, input int cell_no,
                              input direction_type dir, input int draw, input int value);
      lattice_request_t rq;
      rq.cmd      = cmd;
      rq.cell_idx = IDX_W'(cell_no);
      rq.dir      = dir;
      rq.draw     = DRAW_W'(draw);
      rq.value    = CODE_W'(value);
      pending_requests = {pending_requests, rq};
   endtask

   // random traffic, concentrated on edge, corner and centre cells so that the
   // written species actually meet
   task automatic fill_random(input int count);
      lattice_request_t rq;
      int               r, row, col;
      repeat (count) begin
         r = $urandom_range(0, 99);
         rq.cmd = r < 58 ? CMD_STEP : r < 83 ? CMD_WRITE : r < 95 ? CMD_READ : CMD_UNUSED;
         r = $urandom_range(0, 99);
         if (r < 30) begin
            row = $urandom_range(0, 5);
            col = $urandom_range(0, 5);
            row = row < 3 ? row : row + 58;
            col = col < 3 ? col : col + 58;
            rq.cell_idx = IDX_W'(row * SIDE + col);
         end else if (r < 45) begin
            rq.cell_idx = IDX_W'($urandom_range(30, 32) * SIDE + $urandom_range(30, 32));
         end else begin
            rq.cell_idx = IDX_W'($urandom_range(0, CELLS - 1));
         end
         rq.dir   = direction_type'($urandom_range(0, 7));
         rq.draw  = DRAW_W'($urandom_range(0, 65535));
         rq.value = CODE_W'($urandom_range(0, 7));
         pending_requests = {pending_requests, rq};
      end
   endtask

   // sender stays quiet until every expected result is back, then idles before returning
   task automatic wait_drained();
      while (pending_requests.size() != 0 || expected_results.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin : run_test
      int          lim_a, lim_b;
      logic [63:0] wide;
      for (int k = 0; k < CELLS; k++) cells[k] = '0;
      cfg_species   = RST_SPECIES_COUNT;
      cfg_dominance = RST_DOMINANCE;
      cfg_eight     = RST_EIGHT_NB;
      cfg_wrap      = RST_WRAP_EDGES;
      cfg_migrate   = RST_MIGRATE_LIMIT;
      cfg_interact  = RST_INTERACT_LIMIT;
      reset      = 1'b1;
      req_tdata  = '0;
      req_tuser  = CMD_STEP;
      req_tvalid = 1'b0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_index  = CSR_SPECIES_COUNT;
      csr_wdata  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // three species in a cycle 1 > 2 > 3 > 1; codes 4 and 5 beat each other
      write_settings(3'd3, 49'h0_0000_0000_a062, 1'b0, 1'b1, 16'd16384, 16'd49152);
      add_request(CMD_WRITE, 100, DIR_UP, 0, 4);
      add_request(CMD_WRITE, 101, DIR_DOWN_RIGHT, 65535, 5);
      add_request(CMD_WRITE, 164, DIR_UP, 0, 2);
      add_request(CMD_WRITE, 228, DIR_UP, 0, 3);
      add_request(CMD_WRITE, 300, DIR_UP, 0, 6);
      add_request(CMD_WRITE, 301, DIR_UP, 0, 7);
      // mutual win above the species count, then predation on an empty neighbour
      add_request(CMD_STEP, 100, DIR_RIGHT, 20000, 0);
      add_request(CMD_STEP, 100, DIR_RIGHT, 20000, 0);
      // neither beats the other; reproduction between two full cells
      add_request(CMD_STEP, 300, DIR_RIGHT, 40000, 0);
      add_request(CMD_STEP, 300, DIR_RIGHT, 65535, 0);
      add_request(CMD_STEP, 164, DIR_DOWN, 30000, 0);
      add_request(CMD_STEP, 228, DIR_UP, 30000, 0);
      add_request(CMD_STEP, 228, DIR_UP, 65535, 0);
      // equal cells, then migration into an empty cell
      add_request(CMD_STEP, 228, DIR_UP, 0, 0);
      add_request(CMD_STEP, 101, DIR_LEFT, 0, 0);
      add_request(CMD_WRITE, 0, DIR_UP, 0, 1);
      add_request(CMD_WRITE, 1, DIR_UP, 0, 3);
      add_request(CMD_STEP, 0, DIR_RIGHT, 49151, 7);
      // diagonals fold onto the low two bits in four-neighbour mode; wrap at corners
      add_request(CMD_STEP, 4095, DIR_DOWN_RIGHT, 16383, 0);
      add_request(CMD_STEP, 0, DIR_UP_LEFT, 16384, 0);
      add_request(CMD_READ, 4095, DIR_DOWN_RIGHT, 65535, 7);
      add_request(CMD_READ, 100, DIR_UP, 0, 0);
      add_request(CMD_UNUSED, 4095, DIR_DOWN_RIGHT, 65535, 7);
      add_request(CMD_WRITE, 301, DIR_UP, 0, 0);
      fill_random(300);
      wait_drained();

      // every species beats every other, reflecting edges, predation nearly always
      write_settings(3'd7, '1, 1'b1, 1'b0, 16'd0, 16'd65535);
      fill_random(300);
      wait_drained();

      // one species, no dominance, migration for all but the top draw
      write_settings(3'd1, '0, 1'b1, 1'b1, 16'd65535, 16'd0);
      fill_random(300);
      wait_drained();

      lim_a = $urandom_range(0, 65535);
      lim_b = $urandom_range(0, 65535);
      wide  = {$urandom(), $urandom()};
      write_settings(3'd5, wide[DOM_W-1:0], 1'b0, 1'b0,
                     LIMIT_W'(lim_a < lim_b ? lim_a : lim_b),
                     LIMIT_W'(lim_a < lim_b ? lim_b : lim_a));
      fill_random(300);
      wait_drained();

      // fully random settings, limits in either order
      repeat (2) begin
         wide = {$urandom(), $urandom()};
         write_settings(CODE_W'($urandom_range(1, 7)), wide[DOM_W-1:0],
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        LIMIT_W'($urandom_range(0, 65535)), LIMIT_W'($urandom_range(0, 65535)));
         fill_random(350);
         wait_drained();
      end

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
